/* hdl/mfkd_pkg.sv */
// Package for the multi-queue FIFO with delete by key.
// Holds sizes, entry and control types, command and status codes and width helpers.
// No dependencies.
package mfkd_pkg;

	// Queue geometry.
	localparam int QUEUE_DEPTH = 16;
	localparam int NUM_QUEUES  = 3;

	// Derived widths: a count holds 0..QUEUE_DEPTH, an index 0..QUEUE_DEPTH-1.
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int SEL_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

	// Fixed widths of the result fields.
	localparam int POS_W = 4;
	localparam int OCC_W = 5;

	// One stored entry.
	typedef struct packed {
		logic [63:0] name;
		logic [63:0] reason;
	} entry_t;

	// Per-row control from the sequencer.
	typedef struct packed {
		logic append;
		logic shift;
		logic keep;
	} row_ctl_t;

	typedef enum logic [1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_SERVE   = 2'd1,
		CMD_REMOVE  = 2'd2,
		CMD_FIND    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_ROTATE,
		S_REPORT
	} state_t;

	// Fit a count into the five-bit result fields (masked when wider).
	function automatic logic [OCC_W-1:0] fit_occ(input logic [CNT_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[OCC_W-1:0];
	endfunction

	// Fit an entry index into the four-bit position field.
	function automatic logic [POS_W-1:0] fit_pos(input logic [IDX_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[POS_W-1:0];
	endfunction

endpackage

/* hdl/multi_fifo_with_key_delete.sv */
// Top level of the multi-queue FIFO with delete by key.
// Depends on mfkd_pkg, mfkd_ctrl, mfkd_row (and mfkd_cell through it).
//
//  Channel  | Handshake           | Fields
//  ---------+---------------------+-----------------------------------------------
//  command  | start, busy         | command, queue_select, name_key, reason_word
//  result   | done (one cycle)    | status, name_out, reason_out, found_position,
//           |                     | removed_count, occupancy
//
// An item is taken when start is high and busy is low; after a decode step its result
// shows with done for enqueue and for any item on a missing or empty queue. Otherwise
// the selected row rotates first: once for serve, n times for remove and find, with
// n the queue's fill, as each entry passes the cell chain's head once, one per cycle.
// Reset clears all fill counts at once; the entries themselves are not cleared.
// The receiver cannot stall: done lasts one cycle, and busy drops after it.
module multi_fifo_with_key_delete
	import mfkd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [1:0]  queue_select,
	input  logic [63:0] name_key,
	input  logic [63:0] reason_word,
	output logic        done,
	output logic [1:0]  status,
	output logic [63:0] name_out,
	output logic [63:0] reason_out,
	output logic [3:0]  found_position,
	output logic [4:0]  removed_count,
	output logic [4:0]  occupancy
);

	row_ctl_t         row_ctl [NUM_QUEUES];
	entry_t           heads   [NUM_QUEUES];
	logic [CNT_W-1:0] counts  [NUM_QUEUES];
	entry_t           din;

	// Sequencer.
	mfkd_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.command        (command),
		.queue_select   (queue_select),
		.name_key       (name_key),
		.reason_word    (reason_word),
		.heads          (heads),
		.counts         (counts),
		.row_ctl        (row_ctl),
		.din            (din),
		.busy           (busy),
		.done           (done),
		.status         (status),
		.name_out       (name_out),
		.reason_out     (reason_out),
		.found_position (found_position),
		.removed_count  (removed_count),
		.occupancy      (occupancy)
	);

	// One cell row per queue.
	for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_row
		mfkd_row u_row (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (row_ctl[q]),
			.din    (din),
			.head   (heads[q]),
			.count  (counts[q])
		);
	end

endmodule

/* hdl/mfkd_cell.sv */
// One storage cell of a queue row: holds one entry and picks its next value.
// Depends on mfkd_pkg.
module mfkd_cell
	import mfkd_pkg::*;
(
	input  logic             clk,
	input  row_ctl_t         ctl,
	input  logic [CNT_W-1:0] count,
	input  logic [IDX_W-1:0] idx,
	input  logic             is_last,
	input  entry_t           din,
	input  entry_t           nbr,
	input  entry_t           head,
	output entry_t           value
);

	entry_t value_q;
	logic   at_tail;
	logic   at_free;

	// Position of this cell relative to the current fill level.
	assign at_free = (count == CNT_W'(idx));
	assign at_tail = (count == (CNT_W'(idx) + CNT_W'(1)));

	// Append writes the first free cell; a shift pulls from the right neighbor,
	// except that the cell at the tail takes the old head when it is kept.
	always_ff @(posedge clk) begin
		if (ctl.append && at_free) begin
			value_q <= din;
		end else if (ctl.shift) begin
			if (ctl.keep && at_tail) begin
				value_q <= head;
			end else if (!is_last) begin
				value_q <= nbr;
			end
		end
	end

	assign value = value_q;

endmodule

/* hdl/mfkd_row.sv */
// One queue: a row of storage cells plus its fill count.
// Depends on mfkd_pkg and mfkd_cell.
module mfkd_row
	import mfkd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  row_ctl_t         ctl,
	input  entry_t           din,
	output entry_t           head,
	output logic [CNT_W-1:0] count
);

	entry_t           cells [QUEUE_DEPTH];
	logic [CNT_W-1:0] count_q;

	// Fill count: append grows it, a shift that drops the head shrinks it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.append) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctl.shift && !ctl.keep) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// Chain of cells, each taking from its right neighbor on a shift.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t nbr;
		if (i < QUEUE_DEPTH - 1) begin : g_mid
			assign nbr = cells[i+1];
		end else begin : g_end
			assign nbr = cells[i];
		end
		mfkd_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.count   (count_q),
			.idx     (IDX_W'(i)),
			.is_last ((i == QUEUE_DEPTH - 1) ? 1'b1 : 1'b0),
			.din     (din),
			.nbr     (nbr),
			.head    (cells[0]),
			.value   (cells[i])
		);
	end

	assign head  = cells[0];
	assign count = count_q;

endmodule

/* hdl/mfkd_ctrl.sv */
// Command sequencer: decodes an item, steps the selected row and builds the result.
// Depends on mfkd_pkg.
module mfkd_ctrl
	import mfkd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       command,
	input  logic [1:0]       queue_select,
	input  logic [63:0]      name_key,
	input  logic [63:0]      reason_word,
	input  entry_t           heads [NUM_QUEUES],
	input  logic [CNT_W-1:0] counts [NUM_QUEUES],
	output row_ctl_t         row_ctl [NUM_QUEUES],
	output entry_t           din,
	output logic             busy,
	output logic             done,
	output logic [1:0]       status,
	output logic [63:0]      name_out,
	output logic [63:0]      reason_out,
	output logic [3:0]       found_position,
	output logic [4:0]       removed_count,
	output logic [4:0]       occupancy
);

	state_t           state_q, state_d;
	cmd_t             cmd_q;
	logic [SEL_W-1:0] qidx_q;
	logic             qok_q;
	logic [63:0]      key_q;
	logic [63:0]      why_q;
	logic [CNT_W-1:0] n_q;
	logic [IDX_W-1:0] step_q;
	logic             found_q;
	status_t          res_status_q;
	logic [63:0]      res_name_q;
	logic [63:0]      res_reason_q;
	logic [POS_W-1:0] res_pos_q;
	logic [CNT_W-1:0] res_gone_q;

	logic [CNT_W-1:0] cur_cnt;
	entry_t           cur_head;
	logic             hit;
	logic             last_step;
	logic             is_full;
	logic             go_rot;
	status_t          dec_status;

	// Selected row's view.
	assign cur_cnt   = counts[qidx_q];
	assign cur_head  = heads[qidx_q];
	assign hit       = (cur_head.name == key_q);
	assign last_step = ((CNT_W'(step_q) + CNT_W'(1)) == n_q);
	assign is_full   = (cur_cnt >= CNT_W'(QUEUE_DEPTH));
	assign go_rot    = qok_q && (cmd_q != CMD_ENQUEUE) && (cur_cnt != '0);

	// Status decided at decode; a find is upgraded to ok when it hits.
	always_comb begin
		dec_status = ST_OK;
		if (!qok_q) begin
			case (cmd_q)
				CMD_ENQUEUE: dec_status = ST_FULL;
				CMD_REMOVE:  dec_status = ST_OK;
				default:     dec_status = ST_EMPTY;
			endcase
		end else begin
			case (cmd_q)
				CMD_ENQUEUE: dec_status = is_full ? ST_FULL : ST_OK;
				CMD_SERVE:   dec_status = (cur_cnt == '0) ? ST_EMPTY : ST_OK;
				CMD_FIND:    dec_status = (cur_cnt == '0) ? ST_EMPTY : ST_NOT_FOUND;
				default:     dec_status = ST_OK;
			endcase
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (start) state_d = S_DECODE;
			S_DECODE: state_d = go_rot ? S_ROTATE : S_REPORT;
			S_ROTATE: if (last_step) state_d = S_REPORT;
			S_REPORT: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Row controls and handshake outputs.
	always_comb begin
		for (int q = 0; q < NUM_QUEUES; q++) begin
			row_ctl[q] = '0;
			if (qok_q && (qidx_q == SEL_W'(q))) begin
				row_ctl[q].append = (state_q == S_DECODE) && (cmd_q == CMD_ENQUEUE) &&
					!is_full;
				row_ctl[q].shift  = (state_q == S_ROTATE);
				row_ctl[q].keep   = (cmd_q == CMD_FIND) || ((cmd_q == CMD_REMOVE) && !hit);
			end
		end
		busy = (state_q != S_IDLE);
		done = (state_q == S_REPORT);
	end

	assign din.name   = key_q;
	assign din.reason = why_q;

	// Item capture and result accumulation.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q  <= cmd_t'(command);
					qidx_q <= SEL_W'(queue_select);
					qok_q  <= (32'(queue_select) < NUM_QUEUES);
					key_q  <= name_key;
					why_q  <= reason_word;
				end
			end
			S_DECODE: begin
				step_q       <= '0;
				n_q          <= (cmd_q == CMD_SERVE) ? CNT_W'(1) : cur_cnt;
				found_q      <= 1'b0;
				res_status_q <= dec_status;
				res_name_q   <= '0;
				res_reason_q <= '0;
				res_pos_q    <= '0;
				res_gone_q   <= '0;
			end
			S_ROTATE: begin
				step_q <= step_q + IDX_W'(1);
				case (cmd_q)
					CMD_SERVE: begin
						res_name_q   <= cur_head.name;
						res_reason_q <= cur_head.reason;
					end
					CMD_REMOVE: begin
						if (hit) res_gone_q <= res_gone_q + CNT_W'(1);
					end
					CMD_FIND: begin
						if (hit && !found_q) begin
							found_q      <= 1'b1;
							res_status_q <= ST_OK;
							res_name_q   <= cur_head.name;
							res_reason_q <= cur_head.reason;
							res_pos_q    <= fit_pos(step_q);
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Result fields; occupancy reads the row count after the command.
	assign status         = res_status_q;
	assign name_out       = res_name_q;
	assign reason_out     = res_reason_q;
	assign found_position = res_pos_q;
	assign removed_count  = fit_occ(res_gone_q);
	assign occupancy      = qok_q ? fit_occ(cur_cnt) : '0;

endmodule

/* hdl/mfkd_checker.sv */
// Port-level checker for the multi-queue FIFO with delete by key, bound to the top.
// Depends on mfkd_pkg and multi_fifo_with_key_delete.
module mfkd_checker
	import mfkd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [63:0] name_out,
	input logic [63:0] reason_out,
	input logic [4:0]  removed_count,
	input logic [4:0]  occupancy
);

	// A result only comes out of an item in progress.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe without an item in progress");

	// After its result the block is free again.
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("block still busy after the result");

	// An accepted item keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted item did not hold the block busy");

	// An empty report carries no entry and no occupancy.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_EMPTY) |->
			(occupancy == '0) && (name_out == '0) && (reason_out == '0))
		else $error("empty report with data");

	// Only a successful remove reports deletions.
	a_removed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && (removed_count != '0) |-> (status == ST_OK))
		else $error("deletions reported with a failing status");

endmodule

bind multi_fifo_with_key_delete mfkd_checker u_mfkd_checker (.*);
